// ----- design/lru_block_cache_assert.svh -----
// Assertion macros for the LRU block cache.
// Used by the top level only.
`ifndef LRU_BLOCK_CACHE_ASSERT_SVH
`define LRU_BLOCK_CACHE_ASSERT_SVH
`define LBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LBC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

// ----- design/lbc_pkg.sv -----
// Package for the LRU block cache: sizes, codes and item types.
// No dependencies.
package lbc_pkg;
  localparam int unsigned Lines = 64;
  localparam int unsigned LineW = $clog2(Lines);
  localparam int unsigned BlockWords = 32;
  localparam int unsigned BeatW = 5;
  localparam int unsigned WordW = $clog2(BlockWords);
  localparam int unsigned AddrW = LineW + WordW;
  localparam int unsigned KeyW = 12;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW = 7;

  localparam logic [1:0] FuncLookup = 2'd0;
  localparam logic [1:0] FuncInsert = 2'd1;
  localparam logic [1:0] FuncUpdate = 2'd2;
  localparam logic [1:0] FuncNone = 2'd3;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatOrder = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  disk;
    logic [7:0]  block_index;
    logic [4:0]  beat;
    logic [63:0] write_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_word;
    logic [4:0]  read_beat;
    logic        last;
  } out_item_t;

  // scan request / answer between sequencer and line scanner
  typedef struct packed {
    logic             start;
    logic [KeyW-1:0]  key;
    logic [LineW:0]   n;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [LineW-1:0] hit_line;
    logic [LineW-1:0] victim;
  } scan_rsp_t;
endpackage

// ----- design/lbc_scan.sv -----
// Line table and scanner: one compare unit walks lines for match and LRU victim.
// Depends on lbc_pkg.
module lbc_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lbc_pkg::scan_req_t               req_i,
  output lbc_pkg::scan_rsp_t               rsp_o,
  input  logic                             wr_i,
  input  logic                             wr_key_i,
  input  logic [lbc_pkg::LineW-1:0]        wr_line_i,
  input  logic [lbc_pkg::KeyW-1:0]         wr_key_val_i,
  input  logic [lbc_pkg::TimeW-1:0]        wr_time_i
);
  logic [lbc_pkg::Lines-1:0] valid_q;
  logic [lbc_pkg::KeyW-1:0]  key_mem [lbc_pkg::Lines];
  logic [lbc_pkg::TimeW-1:0] time_mem [lbc_pkg::Lines];
  logic                      busy_q, done_q, hit_q, inv_q;
  logic                      s1_q, s1_last_q, s1_vld_q;
  logic [lbc_pkg::LineW:0]   idx_q;
  logic [lbc_pkg::LineW-1:0] hit_line_q, vic_q, inv_line_q, s1_line_q;
  logic [lbc_pkg::TimeW-1:0] best_q, s1_time_q;
  logic [lbc_pkg::KeyW-1:0]  key_q, s1_key_q;
  logic [lbc_pkg::LineW:0]   n_q;
  logic [lbc_pkg::LineW-1:0] i;

  assign i = idx_q[lbc_pkg::LineW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      s1_q <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      done_q <= s1_last_q;
      s1_q <= busy_q;
      s1_last_q <= busy_q && (idx_q + 1'b1 == n_q);
      if (wr_i && wr_key_i) valid_q[wr_line_i] <= 1'b1;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (idx_q + 1'b1 == n_q)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // stage 1 reads one line, stage 2 compares it
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      time_mem[wr_line_i] <= wr_time_i;
      if (wr_key_i) key_mem[wr_line_i] <= wr_key_val_i;
    end
    if (req_i.start) begin
      idx_q <= '0;
      key_q <= req_i.key;
      n_q <= req_i.n;
      hit_q <= 1'b0;
      inv_q <= 1'b0;
      best_q <= '1;
      vic_q <= '0;
    end else begin
      if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        s1_vld_q <= valid_q[i];
        s1_key_q <= key_mem[i];
        s1_time_q <= time_mem[i];
        s1_line_q <= i;
      end
      if (s1_q) begin
        if (!s1_vld_q) begin
          if (!inv_q) begin
            inv_q <= 1'b1;
            inv_line_q <= s1_line_q;
          end
        end else begin
          if (!hit_q && s1_key_q == key_q) begin
            hit_q <= 1'b1;
            hit_line_q <= s1_line_q;
          end
          if (s1_time_q <= best_q) begin
            best_q <= s1_time_q;
            vic_q <= s1_line_q;
          end
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit = hit_q;
  assign rsp_o.hit_line = hit_line_q;
  assign rsp_o.victim = inv_q ? inv_line_q : vic_q;
endmodule

// ----- design/lru_block_cache.sv -----
// Top level of the LRU block cache: command sequencer and block data memory.
// Depends on lbc_pkg, lbc_scan and lru_block_cache_assert.svh.
//
// Commands enter on start/cmd_i when busy is low; results leave on
// res_valid_o/res_o for one cycle each and cannot be held off.
// entries_in_use is written on cfg_valid_i/cfg_ready_o with cfg_data_i; the
// user writes it only while idle, not enforced; values are clamped to 2..64.
// Lookup and write beat 0 scan the lines in use through one compare unit,
// one line a cycle. A lookup hit then streams 32 words, one a cycle from
// the data memory read port. Continuation and out-of-order beats skip the
// scan and go through the beat state.
// Reset clears valid bits, the tick counter and any pending write; data,
// keys and times stay undefined until written. No clearing pass.
`include "lru_block_cache_assert.svh"
module lru_block_cache (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  lbc_pkg::in_item_t     cmd_i,
  output logic                  res_valid_o,
  output lbc_pkg::out_item_t    res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [lbc_pkg::CntW-1:0] cfg_data_i
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SDec  = 3'd2;
  localparam logic [2:0] SRead = 3'd3;
  localparam logic [2:0] SBeat = 3'd4;

  logic [2:0] st_q;
  lbc_pkg::in_item_t cmd_q;
  logic [lbc_pkg::CntW-1:0]  cfg_q;
  logic [lbc_pkg::TimeW-1:0] tick_q, tick_nx;
  logic [lbc_pkg::LineW-1:0] pline_q, rline_q;
  logic [1:0]                pmode_q;
  logic [lbc_pkg::BeatW-1:0] pbeat_q;
  logic [lbc_pkg::WordW:0]   rcnt_q;
  logic                      rvld_q;
  logic [lbc_pkg::WordW-1:0] rbeat_q;
  logic [63:0]               data_mem [lbc_pkg::Lines*lbc_pkg::BlockWords];
  logic [63:0]               rdata_q;
  lbc_pkg::scan_req_t        req;
  lbc_pkg::scan_rsp_t        rsp;
  logic                      twr, tkey, dwr, accept;
  logic [lbc_pkg::LineW-1:0] tline, dline;
  logic [lbc_pkg::LineW:0]   n_act;
  logic                      cont_ok;
  logic [1:0]                ostat;
  logic                      oval;

  assign accept = start && !busy;
  assign busy = (st_q != SIdle) || rvld_q;
  assign cfg_ready_o = 1'b1;
  assign tick_nx = (tick_q == '1) ? tick_q : tick_q + 1'b1;

  always_comb begin
    if (cfg_q < 7'd2) n_act = 7'd2;
    else if (cfg_q > 7'(lbc_pkg::Lines)) n_act = 7'(lbc_pkg::Lines);
    else n_act = cfg_q[lbc_pkg::LineW:0];
  end

  assign cont_ok = (pmode_q == cmd_q.func) && (cmd_q.beat == pbeat_q) && (pmode_q != 2'd0);

  assign req.start = (st_q == SIdle) && accept && (cmd_i.func != lbc_pkg::FuncNone) &&
                     (cmd_i.func == lbc_pkg::FuncLookup || cmd_i.beat == '0);
  assign req.key = {cmd_i.disk, cmd_i.block_index};
  assign req.n = n_act;

  always_comb begin
    twr = 1'b0;
    tkey = 1'b0;
    tline = rsp.hit_line;
    dwr = 1'b0;
    dline = pline_q;
    oval = 1'b0;
    ostat = lbc_pkg::StatOk;
    if (st_q == SDec) begin
      unique case (cmd_q.func)
        lbc_pkg::FuncLookup: begin
          twr = rsp.hit;
          if (!rsp.hit) begin
            oval = 1'b1;
            ostat = lbc_pkg::StatMiss;
          end
        end
        lbc_pkg::FuncInsert: begin
          twr = 1'b1;
          if (rsp.hit) begin
            oval = 1'b1;
            ostat = lbc_pkg::StatMiss;
          end else begin
            tkey = 1'b1;
            tline = rsp.victim;
            dwr = 1'b1;
            dline = rsp.victim;
          end
        end
        default: begin
          twr = rsp.hit;
          dwr = rsp.hit;
          dline = rsp.hit_line;
          if (!rsp.hit) begin
            oval = 1'b1;
            ostat = lbc_pkg::StatMiss;
          end
        end
      endcase
    end else if (st_q == SBeat) begin
      oval = !cont_ok || (cmd_q.beat == 5'(lbc_pkg::BlockWords - 1));
      ostat = cont_ok ? lbc_pkg::StatOk : lbc_pkg::StatOrder;
      dwr = cont_ok;
    end
  end

  lbc_scan u_scan (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp),
    .wr_i(twr), .wr_key_i(tkey), .wr_line_i(tline),
    .wr_key_val_i({cmd_q.disk, cmd_q.block_index}), .wr_time_i(tick_nx)
  );

  always_ff @(posedge clk_i) begin
    if (dwr) data_mem[{dline, (st_q == SDec) ? {lbc_pkg::WordW{1'b0}} :
                                               cmd_q.beat[lbc_pkg::WordW-1:0]}]
        <= cmd_q.write_word;
    rdata_q <= data_mem[{rline_q, rcnt_q[lbc_pkg::WordW-1:0]}];
    rbeat_q <= rcnt_q[lbc_pkg::WordW-1:0];
    if (accept) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cfg_q <= 7'd64;
      tick_q <= '0;
      pline_q <= '0;
      pmode_q <= '0;
      pbeat_q <= '0;
      rline_q <= '0;
      rcnt_q <= '0;
      rvld_q <= 1'b0;
      res_valid_o <= 1'b0;
      res_o <= '0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      rvld_q <= 1'b0;
      res_valid_o <= oval || rvld_q;
      if (rvld_q) begin
        res_o <= '{lbc_pkg::StatOk, rdata_q, rbeat_q,
                   rbeat_q == 5'(lbc_pkg::BlockWords - 1)};
      end else begin
        res_o <= '{ostat, 64'd0, 5'd0, 1'b1};
      end
      if (twr) tick_q <= tick_nx;
      unique case (st_q)
        SIdle: begin
          if (req.start) st_q <= SScan;
          else if (accept && cmd_i.func != lbc_pkg::FuncNone) st_q <= SBeat;
        end
        SScan: if (rsp.done) st_q <= SDec;
        SDec: begin
          if (cmd_q.func == lbc_pkg::FuncLookup) begin
            if (rsp.hit) begin
              rline_q <= rsp.hit_line;
              rcnt_q <= '0;
              st_q <= SRead;
            end else st_q <= SIdle;
          end else begin
            st_q <= SIdle;
            pmode_q <= '0;
            pbeat_q <= '0;
            if (dwr) begin
              pline_q <= dline;
              pmode_q <= cmd_q.func;
              pbeat_q <= 5'd1;
            end
          end
        end
        SRead: begin
          rvld_q <= 1'b1;
          rcnt_q <= rcnt_q + 1'b1;
          if (rcnt_q == 6'(lbc_pkg::BlockWords - 1)) st_q <= SIdle;
        end
        SBeat: begin
          st_q <= SIdle;
          if (!cont_ok || cmd_q.beat == 5'(lbc_pkg::BlockWords - 1)) begin
            pmode_q <= '0;
            pbeat_q <= '0;
          end else pbeat_q <= pbeat_q + 1'b1;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  `LBC_ASSERT(a_no_accept_busy, (st_q != SIdle) |-> busy, "busy low while working")
  `LBC_ASSERT(a_last_idle, (res_valid_o && res_o.last) |-> (st_q == SIdle), "last while active")
  `LBC_ASSERT_NEVER(a_pend_mode, pmode_q == lbc_pkg::FuncNone, "bad pending mode")
endmodule
